>>> design/ettc_pkg.sv
// ----------------------------------------------------------------------------
// ettc_pkg
// shared types, constants and the month length table for the epoch time to
// calendar converter
// ----------------------------------------------------------------------------
package ettc_pkg;

   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int REM_W    = 7;
   localparam int WORK_W   = 32;
   localparam int PROD_W   = 64;

   localparam logic [31:0]        EPOCH_RESET   = 32'd1768521600;
   localparam logic [11:0]        SECS_PER_HOUR = 12'd3600;
   localparam logic [YEAR_W-1:0]  FIRST_YEAR    = 12'd1970;
   localparam logic [REM_W-1:0]   DIV_BY_60     = 7'd60;
   localparam logic [REM_W-1:0]   DIV_BY_24     = 7'd24;
   localparam logic [8:0]         DAYS_NORMAL   = 9'd365;
   localparam logic [8:0]         DAYS_LEAP     = 9'd366;

   // reciprocals that give x / 60 and x / 24 exactly for any 32-bit x
   localparam logic [WORK_W-1:0]  RECIP_60      = 32'h8888_8889;
   localparam int                 SHIFT_60      = 37;
   localparam logic [WORK_W-1:0]  RECIP_24      = 32'hAAAA_AAAB;
   localparam int                 SHIFT_24      = 36;

   // residues of the first year, kept as wrapping counters
   localparam logic [1:0] MOD4_INIT   = 2'd2;
   localparam logic [6:0] MOD100_INIT = 7'd70;
   localparam logic [8:0] MOD400_INIT = 9'd370;
   localparam logic [6:0] MOD100_LAST = 7'd99;
   localparam logic [8:0] MOD400_LAST = 9'd399;

   localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
   localparam logic [MONTH_W-1:0] APRIL    = 4'd4;
   localparam logic [MONTH_W-1:0] JUNE     = 4'd6;
   localparam logic [MONTH_W-1:0] SEPTEMBER = 4'd9;
   localparam logic [MONTH_W-1:0] NOVEMBER = 4'd11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_YEAR,
      ST_MONTH,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      SEL_SEC,
      SEL_MIN,
      SEL_HOUR
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        div_step;
      div_sel_type div_sel;
      logic        year_step;
      logic        month_step;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic year_fits;
      logic month_fits;
   } status_type;

   function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                  input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] d;
      begin
         case (month) inside
            FEBRUARY:                      d = leap ? 5'd29 : 5'd28;
            APRIL, JUNE, SEPTEMBER, NOVEMBER: d = 5'd30;
            default:                       d = 5'd31;
         endcase
         return d;
      end
   endfunction

endpackage

>>> design/ettc_if.sv
// ----------------------------------------------------------------------------
// ettc request and response channels
// valid/ready channels carrying one word each
// ----------------------------------------------------------------------------
interface ettc_req_if #(parameter int OFFSET_BITS = 20);
   logic                   valid;
   logic                   ready;
   logic [OFFSET_BITS-1:0] hour_ofs;

   modport source (output valid, output hour_ofs, input ready);
   modport sink   (input valid, input hour_ofs, output ready);
endinterface

interface ettc_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  day;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;

   modport source (output valid, output year, output month, output day,
                   output hour, output minute, output second, input ready);
   modport sink   (input valid, input year, input month, input day,
                   input hour, input minute, input second, output ready);
endinterface

>>> design/ettc_ctrl.sv
// ----------------------------------------------------------------------------
// ettc_ctrl
// sequencer for the divide passes, year and month walks and output load
// ----------------------------------------------------------------------------
module ettc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  ettc_pkg::status_type status,
   output ettc_pkg::cmd_type   cmd
);
   import ettc_pkg::*;

   state_type   state_ff, state_in;
   div_sel_type pass_ff, pass_in;
   logic        rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= SEL_SEC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.div_sel  = pass_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               pass_in  = SEL_SEC;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               unique case (pass_ff)
                  SEL_SEC:  pass_in = SEL_MIN;
                  SEL_MIN:  pass_in = SEL_HOUR;
                  default:  state_in = ST_YEAR;
               endcase
            end
         end
         ST_YEAR: begin
            if (status.year_fits) state_in = ST_MONTH;
            else cmd.year_step = 1'b1;
         end
         ST_MONTH: begin
            if (status.month_fits) state_in = ST_FINISH;
            else cmd.month_step = 1'b1;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> design/ettc_dp.sv
// ----------------------------------------------------------------------------
// ettc_dp
// base register, reciprocal-multiply constant divider, year and month
// walkers and the output register
// ----------------------------------------------------------------------------
module ettc_dp #(
   parameter int OFFSET_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [31:0]            csr_wdata,
   input  logic [OFFSET_BITS-1:0] hour_ofs,
   input  ettc_pkg::cmd_type      cmd,
   output ettc_pkg::status_type   status,
   output logic [11:0]            year,
   output logic [3:0]             month,
   output logic [4:0]             day,
   output logic [4:0]             hour,
   output logic [5:0]             minute,
   output logic [5:0]             second
);
   import ettc_pkg::*;

   logic [31:0]              base_ff, base_in;
   logic [OFFSET_BITS-1:0]   hours_ff, hours_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [WORK_W-1:0]        work_ff, work_in;
   logic                     mul_done_ff, mul_done_in;
   logic [SECOND_W-1:0]      sec_ff, sec_in;
   logic [MINUTE_W-1:0]      min_ff, min_in;
   logic [HOUR_W-1:0]        hr_ff, hr_in;
   logic [YEAR_W-1:0]        year_ff, year_in;
   logic [1:0]               mod4_ff, mod4_in;
   logic [6:0]               mod100_ff, mod100_in;
   logic [8:0]               mod400_ff, mod400_in;
   logic [MONTH_W-1:0]       month_ff, month_in;
   logic [YEAR_W-1:0]        year_out_ff, year_out_in;
   logic [MONTH_W-1:0]       month_out_ff, month_out_in;
   logic [DAY_W-1:0]         day_out_ff, day_out_in;
   logic [HOUR_W-1:0]        hour_out_ff, hour_out_in;
   logic [MINUTE_W-1:0]      minute_out_ff, minute_out_in;
   logic [SECOND_W-1:0]      second_out_ff, second_out_in;

   logic [REM_W-1:0]  divisor;
   logic [WORK_W-1:0] recip;
   logic [WORK_W-1:0] q_val;
   logic [REM_W-1:0]  qd;
   logic [REM_W-1:0]  rem_val;
   logic              leap;
   logic [8:0]        diy;
   logic [DAY_W-1:0]  dim;

   // base register, the only reset payload
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= EPOCH_RESET;
      end else begin
         base_ff <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      hours_ff      <= hours_in;
      prod_ff       <= prod_in;
      work_ff       <= work_in;
      mul_done_ff   <= mul_done_in;
      sec_ff        <= sec_in;
      min_ff        <= min_in;
      hr_ff         <= hr_in;
      year_ff       <= year_in;
      mod4_ff       <= mod4_in;
      mod100_ff     <= mod100_in;
      mod400_ff     <= mod400_in;
      month_ff      <= month_in;
      year_out_ff   <= year_out_in;
      month_out_ff  <= month_out_in;
      day_out_ff    <= day_out_in;
      hour_out_ff   <= hour_out_in;
      minute_out_ff <= minute_out_in;
      second_out_ff <= second_out_in;
   end

   always_comb begin
      divisor = (cmd.div_sel == SEL_HOUR) ? DIV_BY_24 : DIV_BY_60;
      recip   = (cmd.div_sel == SEL_HOUR) ? RECIP_24 : RECIP_60;
      q_val   = (cmd.div_sel == SEL_HOUR) ? WORK_W'(prod_ff >> SHIFT_24)
                                          : WORK_W'(prod_ff >> SHIFT_60);
      // remainder is below 64, so the low bits are enough
      qd      = q_val[REM_W-1:0] * divisor;
      rem_val = work_ff[REM_W-1:0] - qd;
      leap    = ((mod4_ff == 2'd0) && (mod100_ff != 7'd0)) || (mod400_ff == 9'd0);
      diy     = leap ? DAYS_LEAP : DAYS_NORMAL;
      dim     = month_days(leap, month_ff);
   end

   assign status.div_last   = mul_done_ff;
   assign status.year_fits  = (work_ff < WORK_W'(diy));
   assign status.month_fits = (work_ff < WORK_W'(dim));

   always_comb begin
      base_in       = csr_we ? csr_wdata : base_ff;
      hours_in      = hours_ff;
      prod_in       = prod_ff;
      work_in       = work_ff;
      mul_done_in   = mul_done_ff;
      sec_in        = sec_ff;
      min_in        = min_ff;
      hr_in         = hr_ff;
      year_in       = year_ff;
      mod4_in       = mod4_ff;
      mod100_in     = mod100_ff;
      mod400_in     = mod400_ff;
      month_in      = month_ff;
      year_out_in   = year_out_ff;
      month_out_in  = month_out_ff;
      day_out_in    = day_out_ff;
      hour_out_in   = hour_out_ff;
      minute_out_in = minute_out_ff;
      second_out_in = second_out_ff;

      // seconds come off the base alone; whole hours of the offset join later
      if (cmd.load) begin
         hours_in    = hour_ofs;
         work_in     = base_ff;
         mul_done_in = 1'b0;
         year_in     = FIRST_YEAR;
         mod4_in     = MOD4_INIT;
         mod100_in   = MOD100_INIT;
         mod400_in   = MOD400_INIT;
         month_in    = JANUARY;
      end

      // each pass: multiply by the reciprocal, then take quotient and remainder
      if (cmd.div_step) begin
         if (!mul_done_ff) begin
            prod_in     = PROD_W'(work_ff) * PROD_W'(recip);
            mul_done_in = 1'b1;
         end else begin
            mul_done_in = 1'b0;
            work_in     = (cmd.div_sel == SEL_MIN) ? q_val + WORK_W'(hours_ff) : q_val;
            case (cmd.div_sel)
               SEL_SEC:  sec_in = rem_val[SECOND_W-1:0];
               SEL_MIN:  min_in = rem_val[MINUTE_W-1:0];
               default:  hr_in  = rem_val[HOUR_W-1:0];
            endcase
         end
      end

      if (cmd.year_step) begin
         work_in   = work_ff - WORK_W'(diy);
         year_in   = year_ff + 1'b1;
         mod4_in   = mod4_ff + 1'b1;
         mod100_in = (mod100_ff == MOD100_LAST) ? 7'd0 : mod100_ff + 1'b1;
         mod400_in = (mod400_ff == MOD400_LAST) ? 9'd0 : mod400_ff + 1'b1;
      end

      if (cmd.month_step) begin
         work_in  = work_ff - WORK_W'(dim);
         month_in = month_ff + 1'b1;
      end

      if (cmd.out_load) begin
         year_out_in   = year_ff;
         month_out_in  = month_ff;
         day_out_in    = work_ff[DAY_W-1:0] + 1'b1;
         hour_out_in   = hr_ff;
         minute_out_in = min_ff;
         second_out_in = sec_ff;
      end
   end

   assign year   = year_out_ff;
   assign month  = month_out_ff;
   assign day    = day_out_ff;
   assign hour   = hour_out_ff;
   assign minute = minute_out_ff;
   assign second = second_out_ff;

endmodule

>>> design/epoch_time_to_calendar_core.sv
// ----------------------------------------------------------------------------
// epoch_time_to_calendar_core
// converts an hour offset from a programmable base time into a UTC date
// ----------------------------------------------------------------------------
// sequence from accept to response valid: three divide passes (each a
//   multiply, then a quotient and remainder step), the year walk, the month
//   walk and the output load; its length grows with the year and month
// throughput: one word at a time; the next request is taken once the result
//   lands in the output register, a stalled output holds the finish
// reset: synchronous, clears the sequencer and response valid and loads the
//   base time with 1768521600
module epoch_time_to_calendar_core #(
   parameter int OFFSET_BITS = 20
) (
   input  logic          clock,
   input  logic          reset,
   ettc_req_if.sink      req,
   ettc_rsp_if.source    rsp,
   input  logic          csr_we,
   input  logic [31:0]   csr_wdata
);
   import ettc_pkg::*;

   // command and status bundles between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: idle, three divide passes (by 60, 60, 24), year walk, month
   // walk, then park until the output register frees up
   ettc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: base register, shared reciprocal-multiply divider with a
   // constant divisor, hour offset added to the whole-hour count, leap
   // residue counters, month table lookup and the output word register
   ettc_dp #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .hour_ofs     (req.hour_ofs),
      .cmd          (cmd),
      .status       (status),
      .year         (rsp.year),
      .month        (rsp.month),
      .day          (rsp.day),
      .hour         (rsp.hour),
      .minute       (rsp.minute),
      .second       (rsp.second)
   );

endmodule

>>> design/ettc_checker.sv
// ----------------------------------------------------------------------------
// ettc_checker
// port-level checks on the converter, attached by bind
// ----------------------------------------------------------------------------
module ettc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [11:0] year,
   input logic [3:0]  month,
   input logic [4:0]  day,
   input logic [4:0]  hour,
   input logic [5:0]  minute,
   input logic [5:0]  second
);

   // a waiting response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(year) && $stable(month)
         && $stable(day) && $stable(hour) && $stable(minute) && $stable(second))
      else $error("response word changed while stalled");

   // one word in flight: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (year >= 12'd1970) && (month >= 4'd1) && (month <= 4'd12)
         && (day >= 5'd1))
      else $error("date field out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60))
      else $error("time field out of range");

endmodule

bind epoch_time_to_calendar_core ettc_checker u_ettc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .year      (rsp.year),
   .month     (rsp.month),
   .day       (rsp.day),
   .hour      (rsp.hour),
   .minute    (rsp.minute),
   .second    (rsp.second)
);
